@@ hdl/utf8_whitespace_segmenter_assert.svh @@
// Assertion macros shared by the segmenter modules.
`ifndef UTF8_WHITESPACE_SEGMENTER_ASSERT_SVH
`define UTF8_WHITESPACE_SEGMENTER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define U8WS_CHECK(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Condition that, once seen, implies a consequence on the next edge.
`define U8WS_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/u8ws_pkg.sv @@
// Package: shared constants, types and the space-like code point test.
package u8ws_pkg;

   localparam int unsigned MAX_TEXT_BYTES = 65536;
   localparam int POS_W = $clog2(MAX_TEXT_BYTES + 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_TEXT_BYTES);

   localparam int BYTE_W  = 8;
   localparam int CP_W    = 21;
   localparam int START_W = 16;
   localparam int LEN_W   = 17;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CP_W-1:0] CP_SPACE = 21'h000020;
   localparam logic [CP_W-1:0] CP_BOM   = 21'h00FEFF;

   // One decoded event handed from the decoder to the run tracker.
   typedef struct packed {
      logic             space;  // a space-like code point ended on this byte
      logic [POS_W-1:0] start;  // offset of its lead byte
      logic [POS_W-1:0] next;   // byte count after this byte
      logic             last;   // final byte of the text
      logic             ovf;    // text limit passed
   } seg_event_type;

   function automatic logic is_space_like(input logic [CP_W-1:0] cp);
      logic hit;
      hit = 1'b0;
      if (cp >= 21'h000009 && cp <= 21'h00000D) hit = 1'b1;
      if (cp == CP_SPACE || cp == 21'h0000A0 || cp == 21'h001680) hit = 1'b1;
      if (cp >= 21'h002000 && cp <= 21'h00200A) hit = 1'b1;
      if (cp == 21'h002028 || cp == 21'h002029 || cp == 21'h00202F) hit = 1'b1;
      if (cp == 21'h00205F || cp == 21'h003000 || cp == CP_BOM) hit = 1'b1;
      return hit;
   endfunction

endpackage

@@ hdl/u8ws_channels.sv @@
// Valid/ready channel interfaces for text bytes in and segments out.
interface u8ws_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       final_byte;

   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface u8ws_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] segment_start;
   logic [16:0] segment_length;
   logic        text_done;
   logic        length_overflow;

   modport source (output valid, output segment_start, output segment_length,
                   output text_done, output length_overflow, input ready);
   modport sink   (input valid, input segment_start, input segment_length,
                   input text_done, input length_overflow, output ready);
endinterface

@@ hdl/utf8_whitespace_segmenter.sv @@
// Top level: UTF-8 whitespace segmenter (decoder, event queue, run tracker).
//
//  channel   dir  payload                                              handshake
//  req_bus   in   text_byte[7:0], final_byte                           valid/ready
//  rsp_bus   out  segment_start[15:0], segment_length[16:0],           valid/ready
//                 text_done, length_overflow
//
// One byte is taken per cycle while the queue has room; the decoder updates its
// sequence state in the same cycle the byte is accepted. A segment reaches
// rsp_bus through the queue write and then the output register.
// Only space-like code points and final bytes enter the 4-entry queue; req_bus
// stalls only while that queue is full.
// Synchronous active-high reset clears all counters, the queue and the output.
module utf8_whitespace_segmenter (
   input  logic       clock,
   input  logic       reset,
   u8ws_req_if.sink   req_bus,
   u8ws_rsp_if.source rsp_bus
);
   import u8ws_pkg::*;

   // decoder -> queue
   logic          dec_valid, dec_ready;
   seg_event_type dec_data;

   // queue -> run tracker
   logic          q_valid, q_ready;
   seg_event_type q_data;

   // Decoder: counts bytes, saturates at the text limit and flags overflow,
   // rebuilds code points and marks space-like ones with their lead offset.
   // It pushes only run-closing events and the end-of-text marker.
   u8ws_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .ev_valid (dec_valid),
      .ev_ready (dec_ready),
      .ev_data  (dec_data)
   );

   // Short queue lets the decoder keep taking bytes while a segment waits.
   u8ws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (dec_valid),
      .push_ready (dec_ready),
      .push_data  (dec_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   // Run tracker: keeps the open run's start, emits a segment for a non-empty
   // run on a space or on the final byte, and holds it in the output register
   // until the transaction completes.
   u8ws_run u_run (
      .clock    (clock),
      .reset    (reset),
      .ev_valid (q_valid),
      .ev_ready (q_ready),
      .ev_data  (q_data),
      .rsp_bus  (rsp_bus)
   );

endmodule

@@ hdl/u8ws_decode.sv @@
// Front end: counter and strict UTF-8 decoder, one byte per ready cycle.
`include "utf8_whitespace_segmenter_assert.svh"

module u8ws_decode (
   input  logic                   clock,
   input  logic                   reset,
   u8ws_req_if.sink               req_bus,
   output logic                   ev_valid,
   input  logic                   ev_ready,
   output u8ws_pkg::seg_event_type ev_data
);
   import u8ws_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] seqb_ff, seqb_in;
   logic [1:0]       need_ff, need_in;
   logic [1:0]       size_ff, size_in;
   logic [CP_W-1:0]  pc_ff, pc_in;
   logic             ovf_ff, ovf_in;

   logic             sat;
   logic [POS_W-1:0] at, next;
   logic [7:0]       b, lo, hi;
   logic             cont_ok;
   logic             cp_valid;
   logic [CP_W-1:0]  cp;
   logic [POS_W-1:0] cp_start;
   logic             space;
   logic             accept;

   assign b = req_bus.text_byte;
   assign req_bus.ready = ev_ready;
   assign accept = req_bus.valid && ev_ready;

   always_comb begin
      // past the limit every byte lands on the last offset
      sat  = (pos_ff >= POS_LIMIT);
      at   = sat ? (POS_LIMIT - 1'b1) : pos_ff;
      next = sat ? POS_LIMIT : (pos_ff + 1'b1);

      // tighter second-byte ranges for E0, ED, F0, F4
      lo = 8'h80;
      hi = 8'hBF;
      if (need_ff == size_ff) begin
         if (size_ff == 2'd2 && pc_ff == 21'h0) lo = 8'hA0;
         if (size_ff == 2'd2 && pc_ff == 21'hD) hi = 8'h9F;
         if (size_ff == 2'd3 && pc_ff == 21'h0) lo = 8'h90;
         if (size_ff == 2'd3 && pc_ff == 21'h4) hi = 8'h8F;
      end
      cont_ok = (need_ff != 2'd0) && (b >= lo) && (b <= hi);

      need_in  = need_ff;
      size_in  = size_ff;
      pc_in    = pc_ff;
      seqb_in  = seqb_ff;
      cp_valid = 1'b0;
      cp       = '0;
      cp_start = at;

      if (cont_ok) begin
         pc_in   = {pc_ff[CP_W-7:0], b[5:0]};
         need_in = need_ff - 2'd1;
         if (need_ff == 2'd1) begin
            cp_valid = 1'b1;
            cp       = pc_in;
            cp_start = seqb_ff;
         end
      end else begin
         // broken sequence or idle: byte is looked at as a lead
         need_in = 2'd0;
         if (b < 8'h80) begin
            cp_valid = 1'b1;
            cp       = CP_W'(b);
         end else if (b >= 8'hC2 && b <= 8'hDF) begin
            size_in = 2'd1;
            need_in = 2'd1;
            pc_in   = CP_W'(b[4:0]);
            seqb_in = at;
         end else if (b >= 8'hE0 && b <= 8'hEF) begin
            size_in = 2'd2;
            need_in = 2'd2;
            pc_in   = CP_W'(b[3:0]);
            seqb_in = at;
         end else if (b >= 8'hF0 && b <= 8'hF4) begin
            size_in = 2'd3;
            need_in = 2'd3;
            pc_in   = CP_W'(b[2:0]);
            seqb_in = at;
         end
      end

      space  = cp_valid && is_space_like(cp);
      pos_in = next;
      ovf_in = ovf_ff | sat;
   end

   // only run-closing events and end of text go to the back end
   assign ev_valid      = req_bus.valid && (space || req_bus.final_byte);
   assign ev_data.space = space;
   assign ev_data.start = cp_start;
   assign ev_data.next  = next;
   assign ev_data.last  = req_bus.final_byte;
   assign ev_data.ovf   = ovf_in;

   always_ff @(posedge clock) begin
      if (reset || (accept && req_bus.final_byte)) begin
         pos_ff  <= '0;
         seqb_ff <= '0;
         need_ff <= '0;
         size_ff <= '0;
         pc_ff   <= '0;
         ovf_ff  <= 1'b0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         seqb_ff <= seqb_in;
         need_ff <= need_in;
         size_ff <= size_in;
         pc_ff   <= pc_in;
         ovf_ff  <= ovf_in;
      end
   end

   `U8WS_CHECK(a_need_le_size, need_ff <= size_ff, "continuation count above sequence size")
   `U8WS_CHECK(a_pos_bounded, pos_ff <= POS_LIMIT, "byte count past limit")

endmodule

@@ hdl/u8ws_queue.sv @@
// Short event queue between decoder and run tracker.
`include "utf8_whitespace_segmenter_assert.svh"

module u8ws_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  u8ws_pkg::seg_event_type push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output u8ws_pkg::seg_event_type pop_data
);
   import u8ws_pkg::*;

   seg_event_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   `U8WS_CHECK(a_count_bounded, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue count past depth")
   `U8WS_CHECK_NEXT(a_count_grows, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count did not grow")

endmodule

@@ hdl/u8ws_run.sv @@
// Back end: run tracking and the registered segment output.
module u8ws_run (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    ev_valid,
   output logic                    ev_ready,
   input  u8ws_pkg::seg_event_type ev_data,
   u8ws_rsp_if.source              rsp_bus
);
   import u8ws_pkg::*;

   logic [POS_W-1:0]   run_ff, run_in;
   logic               out_valid_ff, out_valid_in;
   logic [START_W-1:0] start_ff, start_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               done_ff, done_in;
   logic               ovf_ff, ovf_in;

   logic               take;
   logic               emit_close, emit_tail;
   logic [POS_W-1:0]   run_mid;

   assign ev_ready = !out_valid_ff || rsp_bus.ready;
   assign take     = ev_valid && ev_ready;

   always_comb begin
      emit_close = ev_data.space && (ev_data.start > run_ff);
      run_mid    = ev_data.space ? ev_data.next : run_ff;
      emit_tail  = ev_data.last && !emit_close && (run_mid < ev_data.next);

      start_in = emit_close ? START_W'(run_ff) : START_W'(run_mid);
      len_in   = emit_close ? LEN_W'(ev_data.start - run_ff)
                            : LEN_W'(ev_data.next - run_mid);
      done_in  = ev_data.last;
      ovf_in   = ev_data.ovf;

      run_in = ev_data.last ? '0 : run_mid;

      out_valid_in = out_valid_ff && !rsp_bus.ready;
      if (take) out_valid_in = emit_close || emit_tail;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         start_ff <= start_in;
         len_ff   <= len_in;
         done_ff  <= done_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.segment_start   = start_ff;
   assign rsp_bus.segment_length  = len_ff;
   assign rsp_bus.text_done       = done_ff;
   assign rsp_bus.length_overflow = ovf_ff;

endmodule
